// ===== rtl/core/tlqs_pkg.sv =====
// Shared types and constants for the three-level queue scheduler.
`default_nettype none

package tlqs_pkg;

    // Fixed field widths of the stream words
    localparam int ID_W        = 4;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int LEVEL_W     = 2;
    localparam int QUANTUM_W   = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int NUM_LEVELS      = 3;
    localparam int CMD_QUEUE_DEPTH = 2;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 4;
    localparam int DEF_BURST_BITS  = 16;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 4'd2;

    typedef logic [LEVEL_W-1:0] lvl_t;

    localparam lvl_t LEVEL_HI  = 2'd0;
    localparam lvl_t LEVEL_MID = 2'd1;
    localparam lvl_t LEVEL_LO  = 2'd2;

    typedef enum logic [1:0] {
        CMD_ARRIVE = 2'd0,
        CMD_REJECT = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED  = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_INVALID   = 3'd2,
        STAT_IDLE_TICK = 3'd3,
        STAT_RAN       = 3'd4
    } status_t;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        cmd_kind_t          kind;
        lvl_t               level;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlqs_front.sv =====
// Front end: accepts input words and classifies them into commands.
`default_nettype none

module tlqs_front #(
    parameter int ID_BITS    = tlqs_pkg::DEF_ID_BITS,
    parameter int BURST_BITS = tlqs_pkg::DEF_BURST_BITS
) (
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // proc_id [3:0], burst [19:4], prio [22:20], zero [23]
    input  wire logic [tlqs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // mode [0]
    input  wire logic                            s_axis_tuser,
    input  wire logic                            cmdq_full,
    output logic                                 cmdq_push,
    output tlqs_pkg::cmd_t                       cmdq_cmd
);
    import tlqs_pkg::*;

    logic [ID_W-1:0]    in_id;
    logic [BURST_W-1:0] in_burst;
    logic [PRIO_W-1:0]  in_prio;
    logic               prio_ok;
    lvl_t               prio_level;
    logic               arrival_ok;

    assign in_id    = s_axis_tdata[ID_W-1:0];
    assign in_burst = s_axis_tdata[ID_W+BURST_W-1:ID_W];
    assign in_prio  = s_axis_tdata[ID_W+BURST_W+PRIO_W-1:ID_W+BURST_W];

    // Map priority to level, two priorities per level
    always_comb
    begin
        prio_ok    = 1'b1;
        prio_level = LEVEL_HI;
        unique case (in_prio) inside
            3'd1, 3'd2: prio_level = LEVEL_HI;
            3'd3, 3'd4: prio_level = LEVEL_MID;
            3'd5, 3'd6: prio_level = LEVEL_LO;
            default:    prio_ok    = 1'b0;
        endcase
    end

    // Reject bad priorities, zero bursts and values wider than the stored fields
    assign arrival_ok = prio_ok && (in_burst != '0)
                        && ((in_burst >> BURST_BITS) == '0)
                        && ((in_id >> ID_BITS) == '0);

    assign s_axis_tready = !cmdq_full;
    assign cmdq_push     = s_axis_tvalid && !cmdq_full;

    // Build the command word
    always_comb
    begin
        cmdq_cmd.level = prio_level;
        cmdq_cmd.id    = in_id;
        cmdq_cmd.burst = in_burst;
        if (s_axis_tuser)
        begin
            cmdq_cmd.kind = CMD_TICK;
        end
        else if (arrival_ok)
        begin
            cmdq_cmd.kind = CMD_ARRIVE;
        end
        else
        begin
            cmdq_cmd.kind = CMD_REJECT;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlqs_cmd_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module tlqs_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tlqs_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output tlqs_pkg::cmd_t      head_cmd,
    output logic                not_empty
);
    import tlqs_pkg::*;

    localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_QUEUE_DEPTH);

    cmd_t             slot_reg [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold command payloads
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlqs_back.sv =====
// Back end: level queues, tick execution and the result register.
`default_nettype none

module tlqs_back #(
    parameter int QUEUE_DEPTH = tlqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = tlqs_pkg::DEF_ID_BITS,
    parameter int BURST_BITS  = tlqs_pkg::DEF_BURST_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    input  wire tlqs_pkg::cmd_t                   cmd,
    output logic                                  cmd_pop,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tlqs_pkg::QUANTUM_W-1:0]   cfg_wr_data,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // run_id [3:0], run_level [5:4], remaining [21:6], finished [22],
    // slice_expired [23]
    output logic [tlqs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status [2:0]
    output logic [tlqs_pkg::STATUS_W-1:0]         m_axis_tuser
);
    import tlqs_pkg::*;

    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [BURST_BITS-1:0] burst;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT_RD,
        S_ROT_WR,
        S_SEL,
        S_EXEC
    } state_t;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] adj;
        adj = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
        return SLOT_W'(adj);
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input lvl_t lvl,
                                                   input logic [SLOT_W-1:0] slot);
        return MEM_AW'(lvl) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(slot);
    endfunction

    // Queue storage
    entry_t              mem [MEM_DEPTH];
    entry_t              rd_data_reg;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    logic [MEM_AW-1:0]   mem_raddr;

    // Control state
    state_t              state_reg, state_next;
    lvl_t                sel_lvl_reg, sel_lvl_next;
    logic [SLOT_W-1:0]   head_reg [NUM_LEVELS];
    logic [SLOT_W-1:0]   head_next [NUM_LEVELS];
    logic [CNT_W-1:0]    count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]    count_next [NUM_LEVELS];
    logic [QUANTUM_W-1:0] slice_reg, slice_next;
    logic                rot_pend_reg, rot_pend_next;
    logic [QUANTUM_W-1:0] quantum_reg, quantum_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    lvl_t                out_level_reg, out_level_next;
    logic [BURST_W-1:0]  out_rem_reg, out_rem_next;
    logic                out_fin_reg, out_fin_next;
    logic                out_exp_reg, out_exp_next;

    // Derived values
    logic                out_free;
    lvl_t                lvl_sel;
    lvl_t                pick_lvl;
    logic                any_busy;
    logic [SLOT_W-1:0]   head_cur;
    logic [CNT_W-1:0]    count_cur;
    logic [SLOT_W-1:0]   tail_slot;
    logic [SLOT_W-1:0]   head_cur_inc;
    logic [SLOT_W-1:0]   head0_inc;
    logic [SLOT_W-1:0]   tail0_slot;
    logic [BURST_BITS-1:0] dec_burst;
    logic [QUANTUM_W-1:0] q_eff;
    logic [QUANTUM_W-1:0] slice_inc;

    assign out_free = !out_valid_reg || m_axis_tready;

    // Highest non-empty level
    always_comb
    begin
        any_busy = 1'b1;
        if (count_reg[0] != '0)
        begin
            pick_lvl = LEVEL_HI;
        end
        else if (count_reg[1] != '0)
        begin
            pick_lvl = LEVEL_MID;
        end
        else if (count_reg[2] != '0)
        begin
            pick_lvl = LEVEL_LO;
        end
        else
        begin
            pick_lvl = LEVEL_HI;
            any_busy = 1'b0;
        end
    end

    // One level index drives the per-level lookups, except the level-one rotation values
    always_comb
    begin
        case (state_reg)
            S_IDLE:  lvl_sel = cmd.level;
            S_SEL:   lvl_sel = pick_lvl;
            default: lvl_sel = sel_lvl_reg;
        endcase
    end

    assign head_cur     = head_reg[lvl_sel];
    assign count_cur    = count_reg[lvl_sel];
    assign tail_slot    = wrap_slot(SUM_W'(head_cur) + SUM_W'(count_cur));
    assign head_cur_inc = wrap_slot(SUM_W'(head_cur) + SUM_W'(1));
    assign head0_inc    = wrap_slot(SUM_W'(head_reg[0]) + SUM_W'(1));
    assign tail0_slot   = wrap_slot(SUM_W'(head_reg[0]) + SUM_W'(count_reg[0]));
    assign dec_burst    = rd_data_reg.burst - BURST_BITS'(rd_data_reg.burst != '0);
    assign q_eff        = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign slice_inc    = slice_reg + QUANTUM_W'(1);

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        sel_lvl_next    = sel_lvl_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        slice_next      = slice_reg;
        rot_pend_next   = rot_pend_reg;
        quantum_next    = cfg_wr_en ? cfg_wr_data : quantum_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_level_next  = out_level_reg;
        out_rem_next    = out_rem_reg;
        out_fin_next    = out_fin_reg;
        out_exp_next    = out_exp_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_TICK:
                        begin
                            cmd_pop       = 1'b1;
                            rot_pend_next = 1'b0;
                            if (rot_pend_reg && (count_reg[0] != '0))
                            begin
                                state_next = S_ROT_RD;
                            end
                            else
                            begin
                                state_next = S_SEL;
                            end
                        end
                        CMD_ARRIVE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop         = 1'b1;
                                out_valid_next  = 1'b1;
                                out_id_next     = '0;
                                out_level_next  = '0;
                                out_rem_next    = '0;
                                out_fin_next    = 1'b0;
                                out_exp_next    = 1'b0;
                                if (count_cur >= DEPTH_CNT)
                                begin
                                    out_status_next = STAT_FULL;
                                end
                                else
                                begin
                                    out_status_next     = STAT_ACCEPTED;
                                    mem_we              = 1'b1;
                                    mem_waddr           = mem_addr(lvl_sel, tail_slot);
                                    mem_wdata.id        = ID_BITS'(cmd.id);
                                    mem_wdata.burst     = BURST_BITS'(cmd.burst);
                                    count_next[lvl_sel] = count_cur + CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop         = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_INVALID;
                                out_id_next     = '0;
                                out_level_next  = '0;
                                out_rem_next    = '0;
                                out_fin_next    = 1'b0;
                                out_exp_next    = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_ROT_RD:
            begin
                // Fetch the level-one head that used up its slice
                mem_re     = 1'b1;
                mem_raddr  = mem_addr(LEVEL_HI, head_reg[0]);
                state_next = S_ROT_WR;
            end
            S_ROT_WR:
            begin
                // Move it to the tail
                mem_we       = 1'b1;
                mem_waddr    = mem_addr(LEVEL_HI, tail0_slot);
                mem_wdata    = rd_data_reg;
                head_next[0] = head0_inc;
                state_next   = S_SEL;
            end
            S_SEL:
            begin
                if (any_busy)
                begin
                    sel_lvl_next = pick_lvl;
                    mem_re       = 1'b1;
                    mem_raddr    = mem_addr(lvl_sel, head_cur);
                    state_next   = S_EXEC;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_IDLE_TICK;
                    out_id_next     = '0;
                    out_level_next  = '0;
                    out_rem_next    = '0;
                    out_fin_next    = 1'b0;
                    out_exp_next    = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    // Serve one unit to the head and write it back
                    mem_we          = 1'b1;
                    mem_waddr       = mem_addr(lvl_sel, head_cur);
                    mem_wdata.id    = rd_data_reg.id;
                    mem_wdata.burst = dec_burst;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_RAN;
                    out_id_next     = ID_W'(rd_data_reg.id);
                    out_level_next  = lvl_sel + LEVEL_W'(1);
                    out_rem_next    = BURST_W'(dec_burst);
                    out_fin_next    = 1'b0;
                    out_exp_next    = 1'b0;
                    if (lvl_sel == LEVEL_HI)
                    begin
                        slice_next = slice_inc;
                    end
                    if (dec_burst == '0)
                    begin
                        // Drop the finished process
                        out_fin_next        = 1'b1;
                        head_next[lvl_sel]  = head_cur_inc;
                        count_next[lvl_sel] = count_cur - CNT_W'(1);
                        if (lvl_sel == LEVEL_HI)
                        begin
                            slice_next = '0;
                        end
                    end
                    else if ((lvl_sel == LEVEL_HI) && (slice_inc >= q_eff))
                    begin
                        out_exp_next  = 1'b1;
                        slice_next    = '0;
                        rot_pend_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_lvl_reg   <= LEVEL_HI;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            slice_reg     <= '0;
            rot_pend_reg  <= 1'b0;
            quantum_reg   <= QUANTUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_lvl_reg   <= sel_lvl_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            slice_reg     <= slice_next;
            rot_pend_reg  <= rot_pend_next;
            quantum_reg   <= quantum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_level_reg  <= out_level_next;
        out_rem_reg    <= out_rem_next;
        out_fin_reg    <= out_fin_next;
        out_exp_reg    <= out_exp_next;
    end

    // Queue memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_exp_reg, out_fin_reg, out_rem_reg, out_level_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/three_level_queue_scheduler.sv =====
// Top level of the three-level queue scheduler.
//
//  Channel   | Dir | Word contents
//  ----------+-----+-------------------------------------------------------------
//  s_axis    | in  | tuser: mode; tdata: proc_id, burst, prio
//  m_axis    | out | tuser: status; tdata: run_id, run_level, remaining,
//            |     |        finished, slice_expired
//  cfg_wr    | in  | quantum (4 bits), written when cfg_wr_en is high
//
// An input word enters the command queue in the cycle it is accepted and
// reaches the back end in the cycle after. There an arrival is handled in
// S_IDLE, an idle tick passes S_IDLE and S_SEL, and a tick that serves a
// process passes S_IDLE, S_SEL and S_EXEC, with S_ROT_RD and S_ROT_WR before
// S_SEL when a level-one head rotates first, as memory reads are registered.
// Reset clears heads, counts, slice state and handshakes; queue storage is
// not cleared and needs no clearing pass.
// A stalled result holds in the output register while the command queue
// keeps taking words until it fills.
`default_nettype none

module three_level_queue_scheduler #(
    parameter int QUEUE_DEPTH = tlqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = tlqs_pkg::DEF_ID_BITS,
    parameter int BURST_BITS  = tlqs_pkg::DEF_BURST_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // proc_id [3:0], burst [19:4], prio [22:20], zero [23]
    input  wire logic [tlqs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode [0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // run_id [3:0], run_level [5:4], remaining [21:6], finished [22],
    // slice_expired [23]
    output logic [tlqs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status [2:0]
    output logic [tlqs_pkg::STATUS_W-1:0]         m_axis_tuser,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tlqs_pkg::QUANTUM_W-1:0]   cfg_wr_data
);
    import tlqs_pkg::*;

    logic cmdq_full;
    logic cmdq_push;
    cmd_t cmdq_in;
    logic cmdq_pop;
    cmd_t cmdq_head;
    logic cmdq_not_empty;

    // Classify input words
    tlqs_front #(
        .ID_BITS    (ID_BITS),
        .BURST_BITS (BURST_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmdq_full     (cmdq_full),
        .cmdq_push     (cmdq_push),
        .cmdq_cmd      (cmdq_in)
    );

    // Decouple the two sides
    tlqs_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmdq_push),
        .push_cmd  (cmdq_in),
        .full      (cmdq_full),
        .pop       (cmdq_pop),
        .head_cmd  (cmdq_head),
        .not_empty (cmdq_not_empty)
    );

    // Execute commands against the level queues
    tlqs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .BURST_BITS  (BURST_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmdq_not_empty),
        .cmd           (cmdq_head),
        .cmd_pop       (cmdq_pop),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== test/three_level_queue_scheduler_test.sv =====
// Self-checking stream testbench for the three-level queue scheduler.
`timescale 1ns / 100ps

module three_level_queue_scheduler_test;

    import tlqs_pkg::*;

    localparam int  DEPTH          = DEF_QUEUE_DEPTH;
    localparam int  LONG_HOLD      = 80;
    localparam int  SETTLE_CYCLES  = 10;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  PHASE_WORDS    = 125;
    localparam int  NUM_PHASES     = 6;
    localparam bit  MODE_ARRIVE    = 1'b0;
    localparam bit  MODE_TICK      = 1'b1;

    // One expected or observed result word
    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    run_id;
        logic [LEVEL_W-1:0] run_level;
        logic [BURST_W-1:0] remaining;
        logic               finished;
        logic               expired;
    } sched_result_t;

    // One row of the directed stimulus
    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic               typed;
        status_t            status;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_wr_en;
    logic [QUANTUM_W-1:0]   cfg_wr_data;

    // Scheduler state mirrored by the predictor
    logic [ID_W-1:0]        lvl_id   [NUM_LEVELS][DEPTH];
    logic [BURST_W-1:0]     lvl_left [NUM_LEVELS][DEPTH];
    int                     lvl_head [NUM_LEVELS];
    int                     lvl_count[NUM_LEVELS];
    int                     slice_ticks;
    bit                     rotate_due;
    int                     quantum_now;

    sched_result_t          pending_results[$];
    dir_row_t               directed_rows[$];
    sched_result_t          got_word;
    int                     mismatches = 0;
    int                     results_seen = 0;
    int                     stall_cycles;
    bit                     tx_idle_on;
    bit                     rx_idle_on;
    bit                     long_hold_done = 1'b0;

    three_level_queue_scheduler DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // Work out the result of one accepted word and advance the mirrored state
    function automatic sched_result_t schedule_word(logic mode, logic [ID_W-1:0] pid,
                                                    logic [BURST_W-1:0] burst,
                                                    logic [PRIO_W-1:0] prio);
        sched_result_t      r;
        int                 lvl;
        int                 slot;
        int                 h;
        int                 q;
        logic [ID_W-1:0]    moved_id;
        logic [BURST_W-1:0] moved_left;
        r.status    = STAT_ACCEPTED;
        r.run_id    = '0;
        r.run_level = '0;
        r.remaining = '0;
        r.finished  = 1'b0;
        r.expired   = 1'b0;
        if (mode == MODE_ARRIVE) begin
            if (burst == 0 || prio < 1 || prio > 6) begin
                r.status = STAT_INVALID;
            end else begin
                lvl = (int'(prio) - 1) / 2;
                if (lvl_count[lvl] >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    slot = (lvl_head[lvl] + lvl_count[lvl]) % DEPTH;
                    lvl_id[lvl][slot]   = pid;
                    lvl_left[lvl][slot] = burst;
                    lvl_count[lvl]++;
                end
            end
        end else begin
            // Rotate a preempted level-one head to the tail first
            if (rotate_due && lvl_count[0] > 0) begin
                moved_id    = lvl_id[0][lvl_head[0]];
                moved_left  = lvl_left[0][lvl_head[0]];
                lvl_head[0] = (lvl_head[0] + 1) % DEPTH;
                slot        = (lvl_head[0] + lvl_count[0] - 1) % DEPTH;
                lvl_id[0][slot]   = moved_id;
                lvl_left[0][slot] = moved_left;
            end
            rotate_due = 1'b0;
            lvl = 0;
            while (lvl < NUM_LEVELS && lvl_count[lvl] == 0)
                lvl++;
            if (lvl == NUM_LEVELS) begin
                r.status = STAT_IDLE_TICK;
            end else begin
                h = lvl_head[lvl];
                if (lvl_left[lvl][h] > 0)
                    lvl_left[lvl][h]--;
                r.status    = STAT_RAN;
                r.run_id    = lvl_id[lvl][h];
                r.run_level = LEVEL_W'(lvl + 1);
                r.remaining = lvl_left[lvl][h];
                if (lvl == 0)
                    slice_ticks = (slice_ticks + 1) & 15;
                if (lvl_left[lvl][h] == 0) begin
                    r.finished = 1'b1;
                    lvl_head[lvl] = (lvl_head[lvl] + 1) % DEPTH;
                    lvl_count[lvl]--;
                    if (lvl == 0)
                        slice_ticks = 0;
                end else if (lvl == 0) begin
                    q = (quantum_now == 0) ? 1 : quantum_now;
                    if (slice_ticks >= q) begin
                        r.expired   = 1'b1;
                        slice_ticks = 0;
                        rotate_due  = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic dir_row_t dir_row(logic mode, logic [ID_W-1:0] id,
                                         logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio,
                                         logic typed, status_t status);
        dir_row_t row;
        row.mode   = mode;
        row.id     = id;
        row.burst  = burst;
        row.prio   = prio;
        row.typed  = typed;
        row.status = status;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void append_row(dir_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Offer one word, wait for it to be taken, then queue its expected result
    task automatic offer_word(logic mode, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                              logic [PRIO_W-1:0] prio, logic typed, status_t status);
        sched_result_t want;
        if (tx_idle_on && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, prio, burst, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = schedule_word(mode, id, burst, prio);
        if (typed) begin
            want.status    = status;
            want.run_id    = '0;
            want.run_level = '0;
            want.remaining = '0;
            want.finished  = 1'b0;
            want.expired   = 1'b0;
        end
        pending_results.insert(pending_results.size(), want);
    endtask

    // Hold until every expected word is back, then let the pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_quantum(int value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[QUANTUM_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        quantum_now = value;
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got_word.status    = status_t'(m_axis_tuser);
            got_word.run_id    = m_axis_tdata[3:0];
            got_word.run_level = m_axis_tdata[5:4];
            got_word.remaining = m_axis_tdata[21:6];
            got_word.finished  = m_axis_tdata[22];
            got_word.expired   = m_axis_tdata[23];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %0h %0h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                check_field("status", pending_results[0].status, got_word.status);
                check_field("run_id", pending_results[0].run_id, got_word.run_id);
                check_field("run_level", pending_results[0].run_level, got_word.run_level);
                check_field("remaining", pending_results[0].remaining, got_word.remaining);
                check_field("finished", pending_results[0].finished, got_word.finished);
                check_field("slice_expired", pending_results[0].expired, got_word.expired);
                void'(pending_results.pop_front());
            end
        end
    end

    // Drive the receiver: random stall bursts plus one long hold-off
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!long_hold_done && results_seen >= 120) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 99) < 15) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // End the run when no word moves for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                 p;
        int                 i;
        int                 pick;
        int                 pct;
        int                 q;
        logic               mode;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        dir_row_t           row;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_ARRIVE;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;

        // Clear the mirrored state to its reset values
        for (i = 0; i < NUM_LEVELS; i++) begin
            lvl_head[i]  = 0;
            lvl_count[i] = 0;
        end
        slice_ticks = 0;
        rotate_due  = 1'b0;
        quantum_now = int'(QUANTUM_RESET);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: idle tick, rejected arrivals, a full level, a rotation
        append_row(dir_row(MODE_TICK, '0, '0, '0, 1'b1, STAT_IDLE_TICK));
        append_row(dir_row(MODE_ARRIVE, 4'd15, 16'hFFFF, 3'd0, 1'b1, STAT_INVALID));
        append_row(dir_row(MODE_ARRIVE, 4'd0, 16'hFFFF, 3'd7, 1'b1, STAT_INVALID));
        append_row(dir_row(MODE_ARRIVE, 4'd9, 16'd0, 3'd1, 1'b1, STAT_INVALID));
        for (i = 0; i < DEPTH; i++)
            append_row(dir_row(MODE_ARRIVE, ID_W'(i), 16'd1, PRIO_W'(5 + i % 2), 1'b1,
                               STAT_ACCEPTED));
        append_row(dir_row(MODE_ARRIVE, 4'd7, 16'd4, 3'd6, 1'b1, STAT_FULL));
        append_row(dir_row(MODE_ARRIVE, 4'd15, 16'd3, 3'd1, 1'b1, STAT_ACCEPTED));
        append_row(dir_row(MODE_ARRIVE, 4'd1, 16'd1, 3'd2, 1'b1, STAT_ACCEPTED));
        append_row(dir_row(MODE_TICK, '0, '0, '0, 1'b0, STAT_RAN));
        append_row(dir_row(MODE_TICK, '0, '0, '0, 1'b0, STAT_RAN));
        append_row(dir_row(MODE_ARRIVE, 4'd2, 16'd1, 3'd1, 1'b1, STAT_ACCEPTED));
        append_row(dir_row(MODE_TICK, '0, '0, '0, 1'b0, STAT_RAN));
        foreach (directed_rows[row_idx]) begin
            row = directed_rows[row_idx];
            offer_word(row.mode, row.id, row.burst, row.prio, row.typed, row.status);
        end

        // Random phases, each under its own quantum and arrival load
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin q = 1;  pct = 15; end
                1: begin q = 15; pct = 30; end
                2: begin q = 0;  pct = 10; end
                3: begin q = 3;  pct = 25; end
                4: begin q = $urandom_range(1, 14); pct = 20; end
                default: begin q = int'(QUANTUM_RESET); pct = 12; end
            endcase
            write_quantum(q);
            tx_idle_on = (p != NUM_PHASES - 1);
            rx_idle_on = (p != NUM_PHASES - 1);
            for (i = 0; i < PHASE_WORDS; i++) begin
                pick  = $urandom_range(0, 99);
                id    = ID_W'($urandom_range(0, 15));
                burst = '0;
                prio  = '0;
                if (pick < pct) begin
                    // Well-formed arrival, mostly short bursts
                    mode  = MODE_ARRIVE;
                    prio  = PRIO_W'($urandom_range(1, 6));
                    pick  = $urandom_range(0, 99);
                    if (pick < 70)
                        burst = BURST_W'($urandom_range(1, 3));
                    else if (pick < 97)
                        burst = BURST_W'($urandom_range(4, 12));
                    else
                        burst = BURST_W'($urandom_range(13, 100));
                end else if (pick < pct + 8) begin
                    // Broken arrival: bad priority or zero burst
                    mode  = MODE_ARRIVE;
                    pick  = $urandom_range(0, 99);
                    burst = BURST_W'($urandom_range(0, 65535));
                    if (pick < 40) begin
                        prio = 3'd0;
                    end else if (pick < 80) begin
                        prio = 3'd7;
                    end else begin
                        prio  = PRIO_W'($urandom_range(0, 7));
                        burst = '0;
                    end
                end else begin
                    // Tick, with random junk on the unused fields
                    mode  = MODE_TICK;
                    burst = BURST_W'($urandom_range(0, 65535));
                    prio  = PRIO_W'($urandom_range(0, 7));
                end
                offer_word(mode, id, burst, prio, 1'b0, STAT_ACCEPTED);
            end
        end

        // Drain the remaining results and let the block settle
        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
